[rtl/otq_pkg.sv]
package otq_pkg;

  localparam int SLOTS       = 16;
  localparam int MAX_RESULTS = 16;
  localparam int IDX_W       = $clog2(SLOTS);
  localparam int RID_W       = $clog2(MAX_RESULTS);
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_CANCEL = 2'd1,
    OP_TICK   = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    KIND_ADDED     = 3'd0,
    KIND_CANCELED  = 3'd1,
    KIND_NOT_FOUND = 3'd2,
    KIND_EXPIRED   = 3'd3,
    KIND_NOTHING   = 3'd4,
    KIND_FULL      = 3'd5
  } kind_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [47:0] expire_time;
    logic [31:0] repeat_interval;
    logic [31:0] cancel_id;
    logic [47:0] now_time;
  } in_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] timer_id;
    logic [47:0] next_expire;
    logic        next_valid;
    logic        last;
  } out_t;

  typedef struct packed {
    logic             capture;
    logic             add_exec;
    logic             cancel_step;
    logic             tick_step;
    logic             pass_end;
    logic             head_step;
    logic             emit;
    logic             first;
    logic [IDX_W-1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic have_best;
    logic cnt_last;
    logic out_free;
    logic emit_last;
  } status_t;

endpackage

[rtl/ordered_timer_queue_core.sv]
// channel   signals                      transaction when
// in        in_valid in_stall in_data    in_valid && !in_stall
// out       out_valid out_stall out_data out_valid && !out_stall
//
// add: capture, write a free slot, a head scan over all slots, then a single result
// cancel: an id scan over all slots, a head scan, then a single result
// tick: min(due + 1, MAX_RESULTS) passes over all slots, a head scan, then one result per expiry (or one nothing)
// the scans over the slot registers go one slot a cycle
// reset is synchronous, active low, and empties the queue at once
// a stalled output holds its result; input is taken only between transactions
module ordered_timer_queue_core
  import otq_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  cmd_t    cmd;
  status_t status;

  otq_controller u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_data.operation),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  otq_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

[rtl/otq_datapath.sv]
module otq_datapath
  import otq_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  in_t     in_data,
  input  cmd_t    cmd,
  output status_t status,
  input  logic    out_stall,
  output logic    out_valid,
  output out_t    out_data
);

  logic              used_r [SLOTS];
  logic              picked_r [SLOTS];
  logic [47:0]       expire_r [SLOTS];
  logic [31:0]       interval_r [SLOTS];
  logic [31:0]       ident_r [SLOTS];
  logic [31:0]       rid_r [MAX_RESULTS];
  logic [31:0]       next_ident_r;
  in_t               cur_r;
  op_t               op_r;
  logic              found_r;
  logic              best_have_r;
  logic [IDX_W-1:0]  best_idx_r;
  logic [47:0]       best_exp_r;
  logic [31:0]       best_id_r;
  logic [31:0]       best_int_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [CNT_W-1:0]  emit_k_r;
  kind_t             res_kind_r;
  logic [31:0]       res_id_r;
  logic [47:0]       head_r;
  logic              head_valid_r;
  logic              out_valid_r;
  out_t              out_r;

  logic              free_any;
  logic [IDX_W-1:0]  free_idx;
  logic              cand;
  logic              better;
  logic              head_upd;
  logic              eff_have;
  logic              eff_head;
  logic [48:0]       rearm_sum;
  logic [47:0]       rearm_val;
  logic              emit_last;
  logic              out_free;
  out_t              res;

  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        free_any = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
  end

  assign eff_have  = cmd.first ? 1'b0 : best_have_r;
  assign cand      = used_r[cmd.idx] && !picked_r[cmd.idx] &&
                     (expire_r[cmd.idx] <= cur_r.now_time);
  assign better    = cand && (!eff_have || (expire_r[cmd.idx] < best_exp_r));
  assign eff_head  = cmd.first ? 1'b0 : head_valid_r;
  assign head_upd  = used_r[cmd.idx] && (!eff_head || (expire_r[cmd.idx] < head_r));
  assign rearm_sum = {1'b0, cur_r.now_time} + {17'b0, best_int_r};
  assign rearm_val = rearm_sum[48] ? {48{1'b1}} : rearm_sum[47:0];
  assign out_free  = !out_valid_r || !out_stall;
  assign emit_last = (op_r != OP_TICK) || (cnt_r == '0) ||
                     (emit_k_r == cnt_r - CNT_W'(1));

  always_comb begin
    res             = '0;
    res.next_expire = head_r;
    res.next_valid  = head_valid_r;
    res.last        = emit_last;
    unique case (op_r)
      OP_ADD: begin
        res.kind     = res_kind_r;
        res.timer_id = res_id_r;
      end
      OP_CANCEL: begin
        res.kind     = found_r ? KIND_CANCELED : KIND_NOT_FOUND;
        res.timer_id = cur_r.cancel_id;
      end
      OP_TICK: begin
        if (cnt_r == '0) begin
          res.kind = KIND_NOTHING;
        end else begin
          res.kind     = KIND_EXPIRED;
          res.timer_id = rid_r[emit_k_r[RID_W-1:0]];
        end
      end
      default: begin
        res.kind = KIND_NOTHING;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_ident_r <= '0;
      out_valid_r  <= 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        used_r[i]   <= 1'b0;
        picked_r[i] <= 1'b0;
      end
    end else begin
      if (cmd.capture) begin
        cur_r       <= in_data;
        op_r        <= op_t'(in_data.operation);
        found_r     <= 1'b0;
        cnt_r       <= '0;
        emit_k_r    <= '0;
        best_have_r <= 1'b0;
        for (int i = 0; i < SLOTS; i++) begin
          picked_r[i] <= 1'b0;
        end
      end
      if (cmd.add_exec) begin
        if (free_any) begin
          used_r[free_idx]     <= 1'b1;
          expire_r[free_idx]   <= cur_r.expire_time;
          interval_r[free_idx] <= cur_r.repeat_interval;
          ident_r[free_idx]    <= next_ident_r;
          res_kind_r           <= KIND_ADDED;
          res_id_r             <= next_ident_r;
          next_ident_r         <= next_ident_r + 32'd1;
        end else begin
          res_kind_r <= KIND_FULL;
          res_id_r   <= '0;
        end
      end
      if (cmd.cancel_step) begin
        if (!found_r && used_r[cmd.idx] && (ident_r[cmd.idx] == cur_r.cancel_id)) begin
          used_r[cmd.idx] <= 1'b0;
          found_r         <= 1'b1;
        end
      end
      if (cmd.tick_step) begin
        if (better) begin
          best_have_r <= 1'b1;
          best_idx_r  <= cmd.idx;
          best_exp_r  <= expire_r[cmd.idx];
          best_id_r   <= ident_r[cmd.idx];
          best_int_r  <= interval_r[cmd.idx];
        end else if (cmd.first) begin
          best_have_r <= 1'b0;
        end
      end
      if (cmd.pass_end && best_have_r) begin
        picked_r[best_idx_r]       <= 1'b1;
        rid_r[cnt_r[RID_W-1:0]]    <= best_id_r;
        cnt_r                      <= cnt_r + CNT_W'(1);
        if (best_int_r != '0) begin
          expire_r[best_idx_r] <= rearm_val;
        end else begin
          used_r[best_idx_r] <= 1'b0;
        end
      end
      if (cmd.head_step) begin
        if (head_upd) begin
          head_r       <= expire_r[cmd.idx];
          head_valid_r <= 1'b1;
        end else if (cmd.first) begin
          head_r       <= '0;
          head_valid_r <= 1'b0;
        end
      end
      if (cmd.emit && out_free) begin
        out_r       <= res;
        out_valid_r <= 1'b1;
        emit_k_r    <= emit_k_r + CNT_W'(1);
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign status.have_best = best_have_r;
  assign status.cnt_last  = (cnt_r == CNT_W'(MAX_RESULTS - 1));
  assign status.out_free  = out_free;
  assign status.emit_last = emit_last;
  assign out_valid        = out_valid_r;
  assign out_data         = out_r;

endmodule

[rtl/otq_controller.sv]
module otq_controller
  import otq_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_op,
  output logic       in_stall,
  input  status_t    status,
  output cmd_t       cmd
);

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_ADD      = 7'b0000010,
    S_CANCEL   = 7'b0000100,
    S_TICK     = 7'b0001000,
    S_TICK_END = 7'b0010000,
    S_HEAD     = 7'b0100000,
    S_EMIT     = 7'b1000000
  } state_t;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             idx_last;

  assign idx_last = (idx_r == IDX_W'(SLOTS - 1));
  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    cmd       = '0;
    cmd.idx   = idx_r;
    cmd.first = (idx_r == '0);
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          if (in_op == OP_ADD) begin
            state_nxt = S_ADD;
          end else if (in_op == OP_CANCEL) begin
            state_nxt = S_CANCEL;
          end else if (in_op == OP_TICK) begin
            state_nxt = S_TICK;
          end
        end
      end
      S_ADD: begin
        cmd.add_exec = 1'b1;
        state_nxt    = S_HEAD;
      end
      S_CANCEL: begin
        cmd.cancel_step = 1'b1;
        idx_nxt         = idx_r + IDX_W'(1);
        if (idx_last) begin
          idx_nxt   = '0;
          state_nxt = S_HEAD;
        end
      end
      S_TICK: begin
        cmd.tick_step = 1'b1;
        idx_nxt       = idx_r + IDX_W'(1);
        if (idx_last) begin
          idx_nxt   = '0;
          state_nxt = S_TICK_END;
        end
      end
      S_TICK_END: begin
        cmd.pass_end = 1'b1;
        if (!status.have_best || status.cnt_last) begin
          state_nxt = S_HEAD;
        end else begin
          state_nxt = S_TICK;
        end
      end
      S_HEAD: begin
        cmd.head_step = 1'b1;
        idx_nxt       = idx_r + IDX_W'(1);
        if (idx_last) begin
          idx_nxt   = '0;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        cmd.emit = 1'b1;
        if (status.out_free && status.emit_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
        idx_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  a_tick_start: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && in_valid && in_op == OP_TICK) |=> (state_r == S_TICK))
    else $error("tick transaction did not start a scan");

  a_idle_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE || state_r == S_EMIT) |-> (idx_r == '0))
    else $error("scan index not cleared outside a scan");

  a_pass_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TICK_END) |=> (state_r == S_TICK || state_r == S_HEAD))
    else $error("bad exit from tick pass");

endmodule
